// File: src/planar_pose_integrator_with_lag_defines.svh
// assertion macros for the pose integrator
`ifndef PLANAR_POSE_INTEGRATOR_WITH_LAG_DEFINES_SVH
`define PLANAR_POSE_INTEGRATOR_WITH_LAG_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PPI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ppi assertion failed");
// next-cycle implication
`define PPI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ppi assertion failed");
`else
`define PPI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PPI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/ppi_pkg.sv
package ppi_pkg;

  // cordic setup
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 30;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [37:0] PI_Q32          = 38'sd13493037705;
  localparam logic signed [37:0] TWO_PI_Q32      = 38'sd26986075409;
  localparam logic signed [37:0] HALF_PI_Q32     = 38'sd6746518852;

  // configuration
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_GAIN  = 8'd1;
  localparam logic [15:0] TIME_STEP_RST = 16'd3277;
  localparam logic [15:0] LAG_GAIN_RST  = 16'd8192;

  // trig unit result
  typedef struct packed {
    logic               done;
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } trig_res_t;

  // arctangent of 2^-i in q2.30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      5'd24: v = 31'd64;
      5'd25: v = 31'd32;
      5'd26: v = 31'd16;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/ppi_if.sv
// tick command channel
interface ppi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cmd_forward;
  logic signed [31:0] cmd_sideways;
  logic signed [31:0] cmd_turn;
  logic [15:0]        noise_forward;
  logic [15:0]        noise_sideways;
  logic [15:0]        noise_turn;
  modport source (output valid, cmd_forward, cmd_sideways, cmd_turn,
                  noise_forward, noise_sideways, noise_turn, input ready);
  modport sink   (input valid, cmd_forward, cmd_sideways, cmd_turn,
                  noise_forward, noise_sideways, noise_turn, output ready);
endinterface

// pose result channel
interface ppi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_heading;
  logic signed [31:0] vel_forward;
  logic signed [31:0] vel_sideways;
  logic signed [31:0] vel_turn;
  modport source (output valid, pose_x, pose_y, pose_heading, vel_forward,
                  vel_sideways, vel_turn, input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, vel_forward,
                  vel_sideways, vel_turn, output ready);
endinterface

// register write channel
interface ppi_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/ppi_mul.sv
// shared registered signed multiplier
module ppi_mul
  import ppi_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [37:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [70:0] p_o
);

  logic signed [70:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 71'(a_i) * 71'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: src/ppi_trig.sv
// range reduction, quadrant fold and iterative cordic
module ppi_trig
  import ppi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] heading_i,
  output trig_res_t          res_o
);

  typedef enum logic [5:0] {
    TR_IDLE = 6'b000001,
    TR_QEST = 6'b000010,
    TR_REM  = 6'b000100,
    TR_CORR = 6'b001000,
    TR_FOLD = 6'b010000,
    TR_CORD = 6'b100000
  } tr_state_e;

  // 2*pi in q32 and a reciprocal just under 2^60 / that, so the quotient
  // estimate is at most one low
  localparam logic [34:0] TWO_PI_U = 35'(TWO_PI_Q32);
  localparam logic [34:0] RECIP    = 35'd42722800;

  tr_state_e st_q, st_d;
  logic [4:0] cnt_q, cnt_d;
  logic done_q, done_d;
  logic neg_q, neg_d, flip_q, flip_d;
  logic [35:0] r_q, r_d;
  logic [12:0] q_q, q_d;
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;

  logic [31:0] mag;
  logic [31:0] mul_a;
  logic [34:0] mul_b;
  logic [66:0] prod;
  logic [47:0] rem;
  logic signed [37:0] rs0, rw, rf;
  logic fl;
  logic signed [33:0] xs, ys, at;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= TR_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    flip_q <= flip_d;
    r_q    <= r_d;
    q_q    <= q_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // reduction multiplier: quotient estimate, then quotient times 2*pi
  assign mul_a = (st_q == TR_QEST) ? r_q[31:0] : {19'b0, q_q};
  assign mul_b = (st_q == TR_QEST) ? RECIP : TWO_PI_U;
  assign prod  = 67'(mul_a) * 67'(mul_b);

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    flip_d = flip_q;
    r_d    = r_q;
    q_d    = q_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;

    mag = heading_i[31] ? 32'(-heading_i) : 32'(heading_i);
    rem = {r_q[31:0], 16'h0000} - prod[47:0];

    // sign back on, reduce to [-pi, pi], fold to [-pi/2, pi/2]
    rs0 = neg_q ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});
    if (rs0 > PI_Q32) begin
      rw = rs0 - TWO_PI_Q32;
    end else if (rs0 < -PI_Q32) begin
      rw = rs0 + TWO_PI_Q32;
    end else begin
      rw = rs0;
    end
    fl = 1'b1;
    if (rw > HALF_PI_Q32) begin
      rf = rw - PI_Q32;
    end else if (rw < -HALF_PI_Q32) begin
      rf = rw + PI_Q32;
    end else begin
      rf = rw;
      fl = 1'b0;
    end

    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = $signed({3'b000, atan_q30(cnt_q)});

    unique case (st_q)
      TR_IDLE: begin
        if (start_i) begin
          neg_d = heading_i[31];
          r_d   = {4'b0000, mag};
          st_d  = TR_QEST;
        end
      end
      TR_QEST: begin
        // quotient of |heading| * 2^16 by 2*pi, possibly one low
        q_d  = 13'(prod >> 44);
        st_d = TR_REM;
      end
      TR_REM: begin
        r_d  = 36'(rem);
        st_d = TR_CORR;
      end
      TR_CORR: begin
        // remainder below two periods, one subtract finishes it
        r_d  = (r_q >= 36'(TWO_PI_U)) ? 36'(r_q - 36'(TWO_PI_U)) : r_q;
        st_d = TR_FOLD;
      end
      TR_FOLD: begin
        flip_d = fl;
        z_d    = 34'((rf + 38'sd2) >>> 2);
        x_d    = CORDIC_GAIN_Q30;
        y_d    = '0;
        cnt_d  = '0;
        st_d   = TR_CORD;
      end
      TR_CORD: begin
        if (!z_q[33]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CORDIC_ITERS - 1)) begin
          done_d = 1'b1;
          st_d   = TR_IDLE;
        end
      end
      default: st_d = TR_IDLE;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.cs   = 32'(flip_q ? -x_q : x_q);
  assign res_o.sn   = 32'(flip_q ? -y_q : y_q);

endmodule

// File: src/planar_pose_integrator_with_lag.sv
// steps from input transaction to result valid:
// three reduction steps, fold, 16 cordic iterations, handoff, 16 multiplies, load
// ticks are handled one at a time, through the single shared multiplier and cordic loop
// input ready only while idle; result register lets the next tick start while one waits
// reset: asynchronous active low, pose and velocities zero, time_step 0.05 and lag_gain 2.0
`include "planar_pose_integrator_with_lag_defines.svh"

module planar_pose_integrator_with_lag
  import ppi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  ppi_in_if.sink   in_ch_i,
  ppi_out_if.source out_ch_o,
  ppi_cfg_if.sink  cfg_ch_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TRIG = 5'b00010,
    ST_MUL0 = 5'b00100,
    ST_MUL1 = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    OP_VF_GAIN, OP_VF_DT, OP_VF_NOISE,
    OP_VS_GAIN, OP_VS_DT, OP_VS_NOISE,
    OP_VT_GAIN, OP_VT_DT, OP_VT_NOISE,
    OP_X_COS, OP_X_SIN, OP_X_DT,
    OP_Y_SIN, OP_Y_COS, OP_Y_DT,
    OP_HEAD
  } op_e;

  function automatic logic signed [71:0] rnd_shift(input logic signed [71:0] v,
                                                   input int s);
    return (v + (72'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  state_e st_q, st_d;
  op_e    op_q, op_d;
  logic [15:0] dt_q, gain_q;
  logic signed [31:0] cmd_q [3];
  logic [15:0] noise_q [3];
  logic signed [31:0] vel_q [3], vel_d [3];
  logic signed [31:0] pose_q [3], pose_d [3];
  logic signed [39:0] t_q, t_d;
  logic signed [71:0] acc_q, acc_d;
  logic out_valid_q, out_valid_d;
  logic signed [31:0] ox_q, oy_q, oh_q, ovf_q, ovs_q, ovt_q;

  logic in_acc, out_acc, load_out;
  logic signed [32:0] d [3];
  logic signed [37:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [70:0] mul_p;
  logic signed [71:0] p, pr;
  trig_res_t trig;

  assign in_ch_i.ready  = (st_q == ST_IDLE);
  assign in_acc         = in_ch_i.valid & in_ch_i.ready;
  assign out_acc        = out_ch_o.valid & out_ch_o.ready;
  assign cfg_ch_i.ready = 1'b1;
  assign load_out       = (st_q == ST_DONE) && (!out_valid_q || out_ch_o.ready);

  ppi_trig u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .heading_i (pose_q[2]),
    .res_o     (trig)
  );

  ppi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // velocity errors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k] = 33'(cmd_q[k]) - 33'(vel_q[k]);
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (op_q)
      OP_VF_GAIN:  begin mul_a = 38'(d[0]); mul_b = $signed({17'b0, gain_q}); end
      OP_VS_GAIN:  begin mul_a = 38'(d[1]); mul_b = $signed({17'b0, gain_q}); end
      OP_VT_GAIN:  begin mul_a = 38'(d[2]); mul_b = $signed({17'b0, gain_q}); end
      OP_VF_NOISE: begin mul_a = 38'(t_q); mul_b = $signed({17'b0, noise_q[0]}); end
      OP_VS_NOISE: begin mul_a = 38'(t_q); mul_b = $signed({17'b0, noise_q[1]}); end
      OP_VT_NOISE: begin mul_a = 38'(t_q); mul_b = $signed({17'b0, noise_q[2]}); end
      OP_VF_DT, OP_VS_DT, OP_VT_DT, OP_X_DT, OP_Y_DT: begin
        mul_a = 38'(t_q);
        mul_b = $signed({17'b0, dt_q});
      end
      OP_X_COS: begin mul_a = 38'(vel_q[0]); mul_b = 33'(trig.cs); end
      OP_X_SIN: begin mul_a = 38'(vel_q[1]); mul_b = 33'(trig.sn); end
      OP_Y_SIN: begin mul_a = 38'(vel_q[0]); mul_b = 33'(trig.sn); end
      OP_Y_COS: begin mul_a = 38'(vel_q[1]); mul_b = 33'(trig.cs); end
      OP_HEAD:  begin mul_a = 38'(vel_q[2]); mul_b = $signed({17'b0, dt_q}); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // sequencer and product post-processing
  always_comb begin
    st_d        = st_q;
    op_d        = op_q;
    t_d         = t_q;
    acc_d       = acc_q;
    vel_d       = vel_q;
    pose_d      = pose_q;
    out_valid_d = out_valid_q;
    p           = 72'(mul_p);
    pr          = '0;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          st_d = ST_TRIG;
        end
      end
      ST_TRIG: begin
        if (trig.done) begin
          op_d = OP_VF_GAIN;
          st_d = ST_MUL0;
        end
      end
      ST_MUL0: st_d = ST_MUL1;
      ST_MUL1: begin
        unique case (op_q)
          OP_VF_GAIN, OP_VS_GAIN, OP_VT_GAIN: t_d = 40'(rnd_shift(p, 12));
          OP_VF_DT, OP_VS_DT, OP_VT_DT:       t_d = 40'(rnd_shift(p, 16));
          OP_VF_NOISE: vel_d[0] = sat32(72'(vel_q[0]) + rnd_shift(p, 14));
          OP_VS_NOISE: vel_d[1] = sat32(72'(vel_q[1]) + rnd_shift(p, 14));
          OP_VT_NOISE: vel_d[2] = sat32(72'(vel_q[2]) + rnd_shift(p, 14));
          OP_X_COS, OP_Y_SIN: acc_d = p;
          OP_X_SIN: begin
            pr  = acc_q - p;
            t_d = 40'(rnd_shift(pr, 30));
          end
          OP_Y_COS: begin
            pr  = acc_q + p;
            t_d = 40'(rnd_shift(pr, 30));
          end
          OP_X_DT: pose_d[0] = sat32(72'(pose_q[0]) + rnd_shift(p, 16));
          OP_Y_DT: pose_d[1] = sat32(72'(pose_q[1]) + rnd_shift(p, 16));
          OP_HEAD: pose_d[2] = sat32(72'(pose_q[2]) + rnd_shift(p, 16));
          default: t_d = t_q;
        endcase
        if (op_q == OP_HEAD) begin
          st_d = ST_DONE;
        end else begin
          op_d = op_e'(op_q + 4'd1);
          st_d = ST_MUL0;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      op_q        <= OP_VF_GAIN;
      out_valid_q <= 1'b0;
      dt_q        <= TIME_STEP_RST;
      gain_q      <= LAG_GAIN_RST;
      for (int k = 0; k < 3; k++) begin
        vel_q[k]  <= '0;
        pose_q[k] <= '0;
      end
    end else begin
      st_q        <= st_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      vel_q       <= vel_d;
      pose_q      <= pose_d;
      if (cfg_ch_i.valid) begin
        if (cfg_ch_i.index == CFG_TIME_STEP) begin
          dt_q <= cfg_ch_i.data;
        end else if (cfg_ch_i.index == CFG_LAG_GAIN) begin
          gain_q <= cfg_ch_i.data;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    acc_q <= acc_d;
    if (in_acc) begin
      cmd_q[0]   <= in_ch_i.cmd_forward;
      cmd_q[1]   <= in_ch_i.cmd_sideways;
      cmd_q[2]   <= in_ch_i.cmd_turn;
      noise_q[0] <= in_ch_i.noise_forward;
      noise_q[1] <= in_ch_i.noise_sideways;
      noise_q[2] <= in_ch_i.noise_turn;
    end
    if (load_out) begin
      ox_q  <= pose_q[0];
      oy_q  <= pose_q[1];
      oh_q  <= pose_q[2];
      ovf_q <= vel_q[0];
      ovs_q <= vel_q[1];
      ovt_q <= vel_q[2];
    end
  end

  // result channel
  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.pose_x       = ox_q;
  assign out_ch_o.pose_y       = oy_q;
  assign out_ch_o.pose_heading = oh_q;
  assign out_ch_o.vel_forward  = ovf_q;
  assign out_ch_o.vel_sideways = ovs_q;
  assign out_ch_o.vel_turn     = ovt_q;

  // checks
  `PPI_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_acc, st_q == ST_TRIG)
  `PPI_ASSERT_IMP(a_trig_done_when_waiting, clk_i, rst_ni, trig.done, st_q == ST_TRIG)
  `PPI_ASSERT_NXT(a_head_ends_tick, clk_i, rst_ni, (st_q == ST_MUL1) && (op_q == OP_HEAD), st_q == ST_DONE)

endmodule
